@@ src/nmea_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared codes, result structures and the hex digit helper.
// ----------------------------------------------------------------------------
package nmea_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_COMMA   = 8'h2c;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A       = 8'h41;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_RMC   = 2'd2;

  localparam logic [1:0] STATUS_EMPTY = 2'd0;
  localparam logic [1:0] STATUS_A     = 2'd1;
  localparam logic [1:0] STATUS_OTHER = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic       status_a;
  } line_summary_t;

  typedef struct packed {
    logic       report;
    logic       have_fix;
    logic [1:0] kind;
    logic       checksum_ok;
    logic [8:0] record_count;
    logic       memory_full;
  } result_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] wide;
    wide = {4'b0000, n};
    if (n <= 4'd9) begin
      return CHAR_ZERO + wide;
    end else begin
      return CHAR_A + wide - 8'd10;
    end
  endfunction

endpackage

@@ src/nmea_sentence_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks NMEA 0183 sentences character by character and tracks GGA/RMC pairs.
// ----------------------------------------------------------------------------
// The input channel carries one received character per request (in_valid,
// in_stall, char_in). A newline ends a sentence and produces exactly one
// request on the output channel (out_valid, out_stall and the result fields);
// every other character produces none.
// One character is taken every cycle while in_stall is low. The result of a
// newline is registered and presented from the output register.
// When the receiver stalls, a second result is kept in a skid register; input
// stall is raised only while that skid register is occupied, so characters
// keep flowing until two results are waiting.
// The minimum length register is written through cfg_valid and cfg_data;
// cfg_ready is always high and the new value applies to every newline taken
// after the write.
// Reset clears the line state and the pair tracking, empties both result
// registers and sets the minimum length to 20.
// ----------------------------------------------------------------------------
module nmea_sentence_checker #(
  parameter int MAX_LINE = 128,
  parameter int RECORDS  = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       report,
  output logic       have_fix,
  output logic [1:0] sentence_kind,
  output logic       checksum_ok,
  output logic [8:0] record_count,
  output logic       memory_full
);
  import nmea_pkg::*;

  localparam logic [8:0] REC_MAX  = 9'(RECORDS);
  localparam logic [8:0] REC_FULL = 9'(RECORDS - 1);

  logic [7:0]    min_length;
  logic          gga_seen;
  logic          rmc_seen;
  logic          fix_flag;
  logic [8:0]    pair_count;
  logic          gga_seen_next;
  logic          rmc_seen_next;
  logic          fix_flag_next;
  logic [8:0]    pair_count_next;
  logic          report_next;

  logic          accept;
  logic          take;
  logic          finish;
  logic          pop;
  line_summary_t summary;
  result_t       result_next;
  result_t       result;
  result_t       skid;
  logic          skid_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign take      = accept && (char_in != CHAR_NEWLINE);
  assign finish    = accept && (char_in == CHAR_NEWLINE);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      min_length <= cfg_data;
    end
  end

  nmea_line #(
    .MAX_LINE(MAX_LINE)
  ) u_line (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .finish    (finish),
    .char_in   (char_in),
    .min_length(min_length),
    .summary   (summary)
  );

  always_comb begin
    gga_seen_next   = gga_seen;
    rmc_seen_next   = rmc_seen;
    fix_flag_next   = fix_flag;
    pair_count_next = pair_count;
    report_next     = 1'b0;
    if (summary.kind != KIND_OTHER) begin
      if (summary.ok) begin
        if (summary.kind == KIND_GGA) begin
          gga_seen_next = 1'b1;
        end
        if (summary.kind == KIND_RMC && !rmc_seen) begin
          fix_flag_next = summary.status_a;
          rmc_seen_next = 1'b1;
        end
        if (gga_seen_next && rmc_seen_next) begin
          gga_seen_next = 1'b0;
          rmc_seen_next = 1'b0;
          report_next   = 1'b1;
          if (pair_count < REC_MAX) begin
            pair_count_next = pair_count + 9'd1;
          end
        end
      end else begin
        fix_flag_next = 1'b0;
        report_next   = 1'b1;
      end
    end
    result_next.report       = report_next;
    result_next.have_fix     = fix_flag_next;
    result_next.kind         = summary.kind;
    result_next.checksum_ok  = summary.ok;
    result_next.record_count = pair_count_next;
    result_next.memory_full  = pair_count_next >= REC_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gga_seen   <= 1'b0;
      rmc_seen   <= 1'b0;
      fix_flag   <= 1'b0;
      pair_count <= '0;
    end else if (finish) begin
      gga_seen   <= gga_seen_next;
      rmc_seen   <= rmc_seen_next;
      fix_flag   <= fix_flag_next;
      pair_count <= pair_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (finish) begin
      if (!out_valid || pop) begin
        result    <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid       <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign report        = result.report;
  assign have_fix      = result.have_fix;
  assign sentence_kind = result.kind;
  assign checksum_ok   = result.checksum_ok;
  assign record_count  = result.record_count;
  assign memory_full   = result.memory_full;

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a request while the output is empty");

  a_pair_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= REC_MAX)
    else $error("pair count exceeds its saturation limit");

  a_report_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && report |-> sentence_kind != KIND_OTHER)
    else $error("report raised for a sentence that is neither GGA nor RMC");

  a_finish_fills: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("newline taken but no result presented");

endmodule

@@ src/nmea_line.sv @@
// ----------------------------------------------------------------------------
// NMEA line tracker
// Keeps the per-line state and judges the line when the newline arrives.
// ----------------------------------------------------------------------------
module nmea_line #(
  parameter int MAX_LINE = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic                    finish,
  input  logic [7:0]              char_in,
  input  logic [7:0]              min_length,
  output nmea_pkg::line_summary_t summary
);
  import nmea_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_LINE);

  logic [7:0] line_length;
  logic [7:0] running_xor;
  logic [7:0] tail_chars [4];
  logic       header_gga_match;
  logic       header_rmc_match;
  logic [3:0] comma_count;
  logic [1:0] status_field_is_a;

  logic [7:0] checksum;
  logic       in_header;
  logic       room;

  function automatic logic [7:0] header_char(input logic rmc, input logic [2:0] pos);
    case (pos)
      3'd0: return 8'h24;
      3'd1: return 8'h47;
      3'd2: return 8'h50;
      3'd3: return rmc ? 8'h52 : 8'h47;
      3'd4: return rmc ? 8'h4d : 8'h47;
      3'd5: return rmc ? 8'h43 : 8'h41;
      default: return 8'h00;
    endcase
  endfunction

  assign in_header = line_length < 8'd6;
  assign room      = line_length < MAX_LEN;

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      line_length       <= '0;
      running_xor       <= '0;
      tail_chars        <= '{default: 8'h00};
      header_gga_match  <= 1'b1;
      header_rmc_match  <= 1'b1;
      comma_count       <= '0;
      status_field_is_a <= STATUS_EMPTY;
    end else if (take && room) begin
      if (in_header) begin
        if (char_in != header_char(1'b0, line_length[2:0])) begin
          header_gga_match <= 1'b0;
        end
        if (char_in != header_char(1'b1, line_length[2:0])) begin
          header_rmc_match <= 1'b0;
        end
      end
      if (line_length != 8'd0) begin
        running_xor <= running_xor ^ char_in;
      end
      if (char_in == CHAR_COMMA) begin
        if (comma_count != 4'hf) begin
          comma_count <= comma_count + 4'd1;
        end
      end else if (comma_count == 4'd2) begin
        status_field_is_a <= (status_field_is_a == STATUS_EMPTY && char_in == CHAR_A)
                             ? STATUS_A : STATUS_OTHER;
      end
      tail_chars[0] <= tail_chars[1];
      tail_chars[1] <= tail_chars[2];
      tail_chars[2] <= tail_chars[3];
      tail_chars[3] <= char_in;
      line_length   <= line_length + 8'd1;
    end
  end

  assign checksum = running_xor ^ tail_chars[0] ^ tail_chars[1] ^ tail_chars[2]
                    ^ tail_chars[3];

  always_comb begin
    summary.kind = KIND_OTHER;
    if (line_length >= 8'd6) begin
      if (header_gga_match) begin
        summary.kind = KIND_GGA;
      end else if (header_rmc_match) begin
        summary.kind = KIND_RMC;
      end
    end
    summary.ok = (line_length >= 8'd5) && room && (line_length > min_length)
                 && (tail_chars[1] == hex_digit(checksum[7:4]))
                 && (tail_chars[2] == hex_digit(checksum[3:0]));
    summary.status_a = status_field_is_a == STATUS_A;
  end

endmodule
